// ===== rtl/convex_zone_enter_leave_tracker_macros.svh =====
// Assertion macros for the convex zone tracker.
// Used by the top level; needs nothing else.
`ifndef CONVEX_ZONE_ENTER_LEAVE_TRACKER_MACROS_SVH
`define CONVEX_ZONE_ENTER_LEAVE_TRACKER_MACROS_SVH

// same-cycle implication
`define CZT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("czt assertion failed");

// next-cycle implication
`define CZT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("czt assertion failed");

`endif

// ===== rtl/czt_pkg.sv =====
// Shared types and codes of the convex zone tracker.
// No dependencies.
package czt_pkg;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_ENTER       = 3'd1,
        EV_LEAVE       = 3'd2,
        EV_PLANES_FULL = 3'd3,
        EV_SET_FULL    = 3'd4
    } t_event;

    localparam logic KIND_ADD_PLANE = 1'b0;
    localparam logic KIND_TEST      = 1'b1;

    typedef struct packed {
        logic start_add;
        logic start_test;
    } t_pu_req;

    typedef struct packed {
        logic done;
        logic in_zone;
        logic full;
    } t_pu_stat;

endpackage

// ===== rtl/czt_plane_unit.sv =====
// Plane table and half-space evaluator; evaluates the loaded planes one after another.
// Depends on czt_pkg.
module czt_plane_unit #(
    parameter int MAX_PLANES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  czt_pkg::t_pu_req  i_req,
    input  logic [47:0]       i_normals,
    input  logic [31:0]       i_offset,
    input  logic [31:0]       i_pos_x,
    input  logic [31:0]       i_pos_y,
    input  logic [31:0]       i_pos_z,
    output czt_pkg::t_pu_stat o_stat
);
    import czt_pkg::*;

    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_PLANES);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_RD   = 4'b0010,
        P_MUL  = 4'b0100,
        P_ACC  = 4'b1000
    } t_pstate;

    logic [79:0] mem [MAX_PLANES];
    logic [79:0] r_rdata;

    t_pstate r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_pi, n_pi;
    logic r_done, n_done, r_inside, n_inside, r_full, n_full;
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [47:0] r_px, r_py, r_pz;
    logic signed [49:0] w_sum;
    logic w_wr;

    assign w_wr = (r_state == P_IDLE) && i_req.start_add && (r_total < MaxCnt);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_total[PW-1:0]] <= {i_offset, i_normals};
        end
        r_rdata <= mem[r_pi[PW-1:0]];
    end

    // offset aligned from Q16.16 to Q.30
    assign w_sum = 50'(r_px) + 50'(r_py) + 50'(r_pz)
                 + $signed({{4{r_rdata[79]}}, r_rdata[79:48], 14'b0});

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_pi     = r_pi;
        n_done   = 1'b0;
        n_inside = r_inside;
        n_full   = r_full;
        unique case (r_state)
            P_IDLE: begin
                if (i_req.start_add) begin
                    n_done = 1'b1;
                    n_inside = 1'b0;
                    n_full = !w_wr;
                    if (w_wr) begin
                        n_total = r_total + 1'b1;
                    end
                end else if (i_req.start_test) begin
                    n_full = 1'b0;
                    n_pi = '0;
                    if (r_total == '0) begin
                        n_done = 1'b1;
                        n_inside = 1'b0;
                    end else begin
                        n_state = P_RD;
                    end
                end
            end
            P_RD:  n_state = P_MUL;
            P_MUL: n_state = P_ACC;
            P_ACC: begin
                if (w_sum > 50'sd0) begin
                    n_done = 1'b1;
                    n_inside = 1'b0;
                    n_state = P_IDLE;
                end else if (r_pi == r_total - 1'b1) begin
                    n_done = 1'b1;
                    n_inside = 1'b1;
                    n_state = P_IDLE;
                end else begin
                    n_pi = r_pi + 1'b1;
                    n_state = P_RD;
                end
            end
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_done  <= n_done;
        end
        r_pi     <= n_pi;
        r_inside <= n_inside;
        r_full   <= n_full;
        if (r_state == P_IDLE && i_req.start_test) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
        end
        if (r_state == P_MUL) begin
            r_px <= $signed(r_rdata[15:0])  * r_pos_x;
            r_py <= $signed(r_rdata[31:16]) * r_pos_y;
            r_pz <= $signed(r_rdata[47:32]) * r_pos_z;
        end
    end

    assign o_stat = '{done: r_done, in_zone: r_inside, full: r_full};

endmodule

// ===== rtl/convex_zone_enter_leave_tracker.sv =====
// Top level of the convex zone enter/leave tracker: member set memory and control.
// Depends on czt_pkg, czt_plane_unit and the macros header.
//
//  channel | dir | fields
//  s       | in  | tuser: kind; tdata: normals, offset, id, position
//  m       | out | tuser: event code; tdata: inside, id, enter/leave counts
//
// Add-plane item: stored unless the plane table is full. Test item: each loaded
// plane is evaluated in turn until the first that rejects, then every member entry
// is scanned through the one read port, each in a read state and a check state.
// After reset a clearing pass writes all SET_DEPTH entries before s_tready rises.
// A result waits in the output register; the next item is taken meanwhile.
`include "convex_zone_enter_leave_tracker_macros.svh"
module convex_zone_enter_leave_tracker #(
    parameter int MAX_PLANES = 8,
    parameter int SET_DEPTH  = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [15:0] normal_x, [31:16] normal_y, [47:32] normal_z, [79:48] plane_offset,
    // [111:80] object_id, [143:112] pos_x, [175:144] pos_y, [207:176] pos_z
    input  logic [207:0]  i_s_tdata,
    input  logic          i_s_tuser,  // kind
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [0] is_inside, [32:1] echo_id, [64:33] entries_total,
    // [96:65] exits_total, [103:97] zero
    output logic [103:0]  o_m_tdata,
    output logic [2:0]    o_m_tuser   // event_code
);
    import czt_pkg::*;

    localparam int SW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam logic [SW:0] LastIdx = (SW + 1)'(SET_DEPTH - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PLANE = 7'b0000100,
        S_RD    = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    logic [32:0] set_mem [SET_DEPTH];  // {valid, id}
    logic [32:0] r_sdata;

    t_state r_state, n_state;
    logic [SW:0] r_sa, n_sa;
    logic r_hit, n_hit, r_free, n_free;
    logic [SW-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic r_kind;
    logic [31:0] r_id;
    logic r_inside, n_inside;
    t_event r_ev, n_ev;
    logic [31:0] r_ent, n_ent, r_ext, n_ext;
    logic r_ovalid, n_ovalid;
    logic [103:0] r_odata;
    logic [2:0] r_ouser;

    logic w_acc;
    logic w_wen;
    logic [SW-1:0] w_waddr;
    logic [32:0] w_wdata;
    t_pu_req w_req;
    t_pu_stat w_stat;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc = i_s_tvalid && o_s_tready;
    assign w_req = '{start_add: w_acc && (i_s_tuser == KIND_ADD_PLANE),
                     start_test: w_acc && (i_s_tuser == KIND_TEST)};

    czt_plane_unit #(.MAX_PLANES(MAX_PLANES)) u_planes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_normals(i_s_tdata[47:0]),
        .i_offset (i_s_tdata[79:48]),
        .i_pos_x  (i_s_tdata[143:112]),
        .i_pos_y  (i_s_tdata[175:144]),
        .i_pos_z  (i_s_tdata[207:176]),
        .o_stat   (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            set_mem[w_waddr] <= w_wdata;
        end
        r_sdata <= set_mem[r_sa[SW-1:0]];
    end

    always_comb begin
        n_state    = r_state;
        n_sa       = r_sa;
        n_hit      = r_hit;
        n_free     = r_free;
        n_hit_idx  = r_hit_idx;
        n_free_idx = r_free_idx;
        n_inside   = r_inside;
        n_ev       = r_ev;
        n_ent      = r_ent;
        n_ext      = r_ext;
        n_ovalid   = r_ovalid && !i_m_tready;
        w_wen      = 1'b0;
        w_waddr    = r_sa[SW-1:0];
        w_wdata    = {1'b0, r_id};
        unique case (r_state)
            S_CLEAR: begin
                w_wen = 1'b1;
                if (r_sa == LastIdx) begin
                    n_state = S_IDLE;
                end else begin
                    n_sa = r_sa + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_PLANE;
                end
            end
            S_PLANE: begin
                if (w_stat.done) begin
                    n_inside = w_stat.in_zone;
                    if (r_kind == KIND_ADD_PLANE) begin
                        n_ev = w_stat.full ? EV_PLANES_FULL : EV_NONE;
                        n_state = S_OUT;
                    end else begin
                        n_ev = EV_NONE;
                        n_sa = '0;
                        n_hit = 1'b0;
                        n_free = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (r_sdata[32]) begin
                    if (!r_hit && r_sdata[31:0] == r_id) begin
                        n_hit = 1'b1;
                        n_hit_idx = r_sa[SW-1:0];
                    end
                end else if (!r_free) begin
                    n_free = 1'b1;
                    n_free_idx = r_sa[SW-1:0];
                end
                if (r_sa == LastIdx) begin
                    n_state = S_WB;
                end else begin
                    n_sa = r_sa + 1'b1;
                    n_state = S_RD;
                end
            end
            S_WB: begin
                n_state = S_OUT;
                if (r_inside && !r_hit) begin
                    if (!r_free) begin
                        n_ev = EV_SET_FULL;
                    end else begin
                        w_wen = 1'b1;
                        w_waddr = r_free_idx;
                        w_wdata = {1'b1, r_id};
                        n_ent = r_ent + 1'b1;
                        n_ev = EV_ENTER;
                    end
                end else if (!r_inside && r_hit) begin
                    w_wen = 1'b1;
                    w_waddr = r_hit_idx;
                    n_ext = r_ext + 1'b1;
                    n_ev = EV_LEAVE;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sa     <= '0;
            r_ent    <= '0;
            r_ext    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sa     <= n_sa;
            r_ent    <= n_ent;
            r_ext    <= n_ext;
            r_ovalid <= n_ovalid;
        end
        r_hit      <= n_hit;
        r_free     <= n_free;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_inside   <= n_inside;
        r_ev       <= n_ev;
        if (w_acc) begin
            r_kind <= i_s_tuser;
            r_id   <= i_s_tdata[111:80];
        end
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_ouser <= r_ev;
            r_odata <= {7'b0, r_ext, r_ent,
                        (r_kind == KIND_TEST) ? r_id : 32'd0,
                        (r_kind == KIND_TEST) && r_inside};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    `CZT_ASSERT_IMP(a_enter_inside, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == EV_ENTER, o_m_tdata[0])
    `CZT_ASSERT_IMP(a_leave_outside, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == EV_LEAVE, !o_m_tdata[0])
    `CZT_ASSERT_NXT(a_ent_only_wb, i_clk, i_rst_n, r_state != S_WB, $stable(r_ent) && $stable(r_ext))
    `CZT_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_s_tready)

endmodule
